@@ hw/rtl/s2i_pkg.sv @@
// shared types, unit suffix table and constants for the decimal string converter
package s2i_pkg;

  localparam int MAX_SUFFIX_CHARS_DEF = 16;
  localparam int UNIT_COUNT = 31;
  localparam int TEXT_CHARS = 9;
  localparam int FRAC_MAX = 19;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_DIGITS = 2'd1;
  localparam logic [1:0] ST_UNKNOWN   = 2'd2;
  localparam logic [1:0] ST_WRAP      = 2'd3;

  localparam logic [1:0] PH_LEAD   = 2'd0;
  localparam logic [1:0] PH_DIGITS = 2'd1;
  localparam logic [1:0] PH_GAP    = 2'd2;
  localparam logic [1:0] PH_SUFFIX = 2'd3;

  typedef struct packed {
    logic [2:0]              kind;
    logic [3:0]              len;
    logic [3:0]              shift;
    logic [31:0]             factor;
    logic [8*TEXT_CHARS-1:0] text;   // string literal, last char in low byte
  } unit_t;

  // one parsed string handed from the front to the back
  typedef struct packed {
    logic [63:0] acc;
    logic [31:0] factor;
    logic [3:0]  shift;
    logic        apply;
    logic [4:0]  fdc;
    logic [1:0]  code;
  } job_t;

  localparam unit_t UNITS [UNIT_COUNT] = '{
    '{3'd0, 4'd2, 4'd0,  32'd1,          72'("mm")},
    '{3'd0, 4'd1, 4'd0,  32'd1000,       72'("m")},
    '{3'd0, 4'd2, 4'd0,  32'd1000000,    72'("km")},
    '{3'd0, 4'd2, 4'd0,  32'd305,        72'("ft")},
    '{3'd0, 4'd2, 4'd0,  32'd914,        72'("yd")},
    '{3'd0, 4'd5, 4'd0,  32'd1609344,    72'("miles")},
    '{3'd1, 4'd4, 4'd0,  32'd1,          72'("mm/s")},
    '{3'd1, 4'd3, 4'd0,  32'd1000,       72'("m/s")},
    '{3'd1, 4'd4, 4'd0,  32'd278,        72'("km/h")},
    '{3'd1, 4'd3, 4'd0,  32'd447,        72'("mph")},
    '{3'd2, 4'd2, 4'd0,  32'd1,          72'("ms")},
    '{3'd2, 4'd1, 4'd0,  32'd1000,       72'("s")},
    '{3'd2, 4'd1, 4'd0,  32'd60000,      72'("m")},
    '{3'd2, 4'd3, 4'd0,  32'd60000,      72'("min")},
    '{3'd2, 4'd1, 4'd0,  32'd3600000,    72'("h")},
    '{3'd3, 4'd1, 4'd0,  32'd1,          72'("N")},
    '{3'd3, 4'd2, 4'd0,  32'd1000,       72'("kN")},
    '{3'd3, 4'd2, 4'd0,  32'd1000000,    72'("MN")},
    '{3'd3, 4'd3, 4'd10, 32'd4555,       72'("lbf")},
    '{3'd4, 4'd2, 4'd0,  32'd1,          72'("kg")},
    '{3'd4, 4'd1, 4'd0,  32'd1000,       72'("t")},
    '{3'd4, 4'd2, 4'd0,  32'd907,        72'("st")},
    '{3'd4, 4'd2, 4'd0,  32'd1016,       72'("lt")},
    '{3'd5, 4'd1, 4'd0,  32'd1,          72'("W")},
    '{3'd5, 4'd2, 4'd0,  32'd1000,       72'("kW")},
    '{3'd5, 4'd2, 4'd0,  32'd1000000,    72'("MW")},
    '{3'd5, 4'd2, 4'd0,  32'd1000000000, 72'("GW")},
    '{3'd5, 4'd2, 4'd0,  32'd746,        72'("hp")},
    '{3'd5, 4'd8, 4'd9,  32'd684,        72'("ft lbf/s")},
    '{3'd6, 4'd7, 4'd0,  32'd1,          72'("N/(m/s)")},
    '{3'd7, 4'd9, 4'd0,  32'd1,          72'("N/(m/s)^2")}
  };

  function automatic logic [63:0] pow10(input logic [4:0] n);
    logic [63:0] p;
    case (n)
      5'd1:  p = 64'd10;
      5'd2:  p = 64'd100;
      5'd3:  p = 64'd1000;
      5'd4:  p = 64'd10000;
      5'd5:  p = 64'd100000;
      5'd6:  p = 64'd1000000;
      5'd7:  p = 64'd10000000;
      5'd8:  p = 64'd100000000;
      5'd9:  p = 64'd1000000000;
      5'd10: p = 64'd10000000000;
      5'd11: p = 64'd100000000000;
      5'd12: p = 64'd1000000000000;
      5'd13: p = 64'd10000000000000;
      5'd14: p = 64'd100000000000000;
      5'd15: p = 64'd1000000000000000;
      5'd16: p = 64'd10000000000000000;
      5'd17: p = 64'd100000000000000000;
      5'd18: p = 64'd1000000000000000000;
      5'd19: p = 64'd10000000000000000000;
      default: p = 64'd1;
    endcase
    return p;
  endfunction

endpackage

@@ hw/rtl/s2i_front.sv @@
// character parser: digits, point, blanks and running suffix match
module s2i_front #(
  parameter int MAX_SUFFIX_CHARS = s2i_pkg::MAX_SUFFIX_CHARS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic [7:0]      character,
  input  logic            has_character,
  input  logic            last,
  input  logic [2:0]      unit_kind,
  output logic            push,
  output s2i_pkg::job_t   job
);

  localparam int LEN_W = $clog2(MAX_SUFFIX_CHARS + 1);

  logic [1:0]                     phase, phase_next;
  logic [63:0]                    acc, acc_next;
  logic                           ovf, ovf_next;
  logic                           pt, pt_next;
  logic                           dig, dig_next;
  logic [4:0]                     fdc, fdc_next;
  logic [LEN_W-1:0]               slen, slen_next;
  logic                           too_long, too_long_next;
  logic [s2i_pkg::UNIT_COUNT-1:0] alive, alive_next;

  logic        done;
  logic        blank;
  logic [67:0] ext;
  logic [3:0]  pos;
  logic        hit;
  logic [31:0] hit_factor;
  logic [3:0]  hit_shift;

  assign blank = (character == 8'h20) || (character == 8'h09);

  always_comb begin
    phase_next    = phase;
    acc_next      = acc;
    ovf_next      = ovf;
    pt_next       = pt;
    dig_next      = dig;
    fdc_next      = fdc;
    slen_next     = slen;
    too_long_next = too_long;
    alive_next    = alive;
    done          = 1'b0;
    pos           = 4'd0;
    ext = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {64'd0, character[3:0]};
    if (has_character) begin
      if (phase_next == s2i_pkg::PH_LEAD) begin
        if (blank) done = 1'b1;
        else phase_next = s2i_pkg::PH_DIGITS;
      end
      if (!done && phase_next == s2i_pkg::PH_DIGITS) begin
        if (character >= 8'h30 && character <= 8'h39) begin
          if (ext[67:64] != 4'd0) ovf_next = 1'b1;
          acc_next = ext[63:0];
          dig_next = 1'b1;
          if (pt && fdc != 5'd31) fdc_next = fdc + 5'd1;
          done = 1'b1;
        end else if (character == 8'h2e && !pt) begin
          pt_next = 1'b1;
          done = 1'b1;
        end else begin
          phase_next = s2i_pkg::PH_GAP;
        end
      end
      if (!done && phase_next == s2i_pkg::PH_GAP) begin
        if (blank) done = 1'b1;
        else phase_next = s2i_pkg::PH_SUFFIX;
      end
      if (!done && phase_next == s2i_pkg::PH_SUFFIX) begin
        if (slen < LEN_W'(MAX_SUFFIX_CHARS)) begin
          for (int i = 0; i < s2i_pkg::UNIT_COUNT; i++) begin
            // compare against the char at this position of each table entry
            if (slen < LEN_W'(s2i_pkg::UNITS[i].len)) begin
              pos = s2i_pkg::UNITS[i].len - 4'd1 - slen[3:0];
              alive_next[i] = alive[i] &&
                              (s2i_pkg::UNITS[i].text[8*pos +: 8] == character);
            end else begin
              alive_next[i] = 1'b0;
            end
          end
          slen_next = slen + LEN_W'(1);
        end else begin
          too_long_next = 1'b1;
        end
      end
    end
  end

  // first table entry that matches the whole suffix
  always_comb begin
    hit        = 1'b0;
    hit_factor = 32'd1;
    hit_shift  = 4'd0;
    for (int i = s2i_pkg::UNIT_COUNT - 1; i >= 0; i--) begin
      if (alive_next[i] && s2i_pkg::UNITS[i].kind == unit_kind &&
          LEN_W'(s2i_pkg::UNITS[i].len) == slen_next) begin
        hit        = 1'b1;
        hit_factor = s2i_pkg::UNITS[i].factor;
        hit_shift  = s2i_pkg::UNITS[i].shift;
      end
    end
  end

  always_comb begin
    job.acc    = acc_next;
    job.factor = hit_factor;
    job.shift  = hit_shift;
    job.apply  = (slen_next != '0);
    job.fdc    = fdc_next;
    if (!dig_next) job.code = s2i_pkg::ST_NO_DIGITS;
    else if ((slen_next != '0 || too_long_next) && (too_long_next || !hit))
      job.code = s2i_pkg::ST_UNKNOWN;
    else if (ovf_next) job.code = s2i_pkg::ST_WRAP;
    else job.code = s2i_pkg::ST_OK;
  end

  assign push = accept && last;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      phase    <= s2i_pkg::PH_LEAD;
      acc      <= '0;
      ovf      <= 1'b0;
      pt       <= 1'b0;
      dig      <= 1'b0;
      fdc      <= '0;
      slen     <= '0;
      too_long <= 1'b0;
      alive    <= '1;
    end else if (accept) begin
      phase    <= phase_next;
      acc      <= acc_next;
      ovf      <= ovf_next;
      pt       <= pt_next;
      dig      <= dig_next;
      fdc      <= fdc_next;
      slen     <= slen_next;
      too_long <= too_long_next;
      alive    <= alive_next;
    end
  end

endmodule

@@ hw/rtl/s2i_queue.sv @@
// two-entry job queue between parser and arithmetic back end
module s2i_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  s2i_pkg::job_t job_in,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output s2i_pkg::job_t job_out
);

  s2i_pkg::job_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  assign full    = (count == 2'd2);
  assign valid   = (count != 2'd0);
  assign job_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= job_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

@@ hw/rtl/s2i_back.sv @@
// suffix multiply, shift and power-of-ten division, one string at a time
module s2i_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  s2i_pkg::job_t job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [63:0]   value,
  output logic [1:0]    status
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL_LO = 3'd1;
  localparam logic [2:0] S_MUL_HI = 3'd2;
  localparam logic [2:0] S_ADD    = 3'd3;
  localparam logic [2:0] S_FRAC   = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  logic [2:0]  state;
  logic [63:0] acc;
  logic [31:0] factor;
  logic [3:0]  shift;
  logic [4:0]  fdc;
  logic [63:0] p_lo, p_hi, v, quo, rem, dvs;
  logic [5:0]  cnt;
  logic [95:0] sum;
  logic [64:0] trial;

  assign pop       = (state == S_IDLE) && q_valid;
  assign out_valid = (state == S_OUT);
  assign sum       = {32'd0, p_lo} + {p_hi, 32'd0};
  assign trial     = {rem, quo[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (q_valid) begin
          acc    <= job.acc;
          factor <= job.factor;
          shift  <= job.shift;
          fdc    <= job.fdc;
          v      <= job.acc;
          if (job.code != s2i_pkg::ST_OK) begin
            value  <= '0;
            status <= job.code;
            state  <= S_OUT;
          end else if (job.apply) begin
            state <= S_MUL_LO;
          end else begin
            state <= S_FRAC;
          end
        end
        S_MUL_LO: begin
          p_lo  <= acc[31:0] * factor;
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          p_hi  <= acc[63:32] * factor;
          state <= S_ADD;
        end
        S_ADD: begin
          if (sum[95:64] != 32'd0) begin
            value  <= '0;
            status <= s2i_pkg::ST_WRAP;
            state  <= S_OUT;
          end else begin
            v     <= sum[63:0] >> shift;
            state <= S_FRAC;
          end
        end
        S_FRAC: begin
          status <= s2i_pkg::ST_OK;
          if (fdc > 5'(s2i_pkg::FRAC_MAX)) begin
            value <= '0;
            state <= S_OUT;
          end else if (fdc == 5'd0) begin
            value <= v;
            state <= S_OUT;
          end else begin
            quo   <= v;
            rem   <= '0;
            dvs   <= s2i_pkg::pow10(fdc);
            cnt   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          if (trial >= {1'b0, dvs}) begin
            rem <= 64'(trial - {1'b0, dvs});
            quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= trial[63:0];
            quo <= {quo[62:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) state <= S_FIN;
        end
        S_FIN: begin
          value <= quo;
          state <= S_OUT;
        end
        S_OUT: if (!out_stall) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hw/rtl/decimal_unit_string_to_integer.sv @@
// top level of the decimal quantity string to integer converter
// Input channel: one character per transfer (in_valid/in_stall) with
// has_character, last and unit_kind. The parser takes one transfer per
// cycle; in_stall rises only when the two-entry job queue is full.
// A transfer with last set ends the string; unit_kind is taken from it.
// Output channel: one value/status per string (out_valid/out_stall).
// Per string the back end takes a job in S_IDLE, runs the suffix multiply
// (two 32x32 partial products in S_MUL_LO and S_MUL_HI, their sum in S_ADD)
// when there is a suffix, checks the fraction in S_FRAC and, when there are
// 1 to 19 fraction digits, divides bit-serially by ten to that power in
// S_DIV and S_FIN; a job with an error code goes straight to the output.
// The back end takes no new string until the result before it is taken.
// A result is held on the ports until a transfer with out_stall low;
// meanwhile the parser keeps taking characters until the queue fills.
// Reset clears the parser, empties the queue and drops out_valid.
module decimal_unit_string_to_integer #(
  parameter int MAX_SUFFIX_CHARS = s2i_pkg::MAX_SUFFIX_CHARS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  character,
  input  logic        has_character,
  input  logic        last,
  input  logic [2:0]  unit_kind,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] value,
  output logic [1:0]  status
);

  logic          accept;
  logic          push;
  logic          full;
  logic          pop;
  logic          q_valid;
  s2i_pkg::job_t job_in;
  s2i_pkg::job_t job_out;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  s2i_front #(.MAX_SUFFIX_CHARS(MAX_SUFFIX_CHARS)) u_front (
    .clk(clk), .rst(rst), .accept(accept), .character(character),
    .has_character(has_character), .last(last), .unit_kind(unit_kind),
    .push(push), .job(job_in)
  );

  s2i_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .job_in(job_in), .full(full),
    .pop(pop), .valid(q_valid), .job_out(job_out)
  );

  s2i_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .job(job_out), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .value(value),
    .status(status)
  );

endmodule

@@ hw/rtl/s2i_checker.sv @@
// port checks for the converter and their binding to the top level
module s2i_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] value,
  input logic [1:0]  status
);

  // any error status carries a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != s2i_pkg::ST_OK |-> value == 64'd0)
    else $error("nonzero value with error status");

  // no result right after reset
  a_rst_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result present after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(status))
    else $error("stalled result changed");

endmodule

bind decimal_unit_string_to_integer s2i_checker u_s2i_checker (.*);

@@ dv/decimal_unit_string_to_integer_test.sv @@
// self-checking test of the decimal quantity string converter
module decimal_unit_string_to_integer_test;

  localparam int SUFFIX_MAX = s2i_pkg::MAX_SUFFIX_CHARS_DEF;
  localparam int STALL_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  character = 8'd0;
  logic        has_character = 1'b0;
  logic        last = 1'b0;
  logic [2:0]  unit_kind = 3'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] value;
  logic [1:0]  status;

  decimal_unit_string_to_integer u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .character(character), .has_character(has_character), .last(last),
    .unit_kind(unit_kind), .out_valid(out_valid), .out_stall(out_stall),
    .value(value), .status(status)
  );

  always #5 clk = ~clk;

  typedef struct {
    logic [63:0] val;
    logic [1:0]  stat;
  } conversion_t;

  // parser copy
  logic [1:0]  phase;
  logic [63:0] acc;
  logic        wrapped, point, any_digit, too_long;
  logic [4:0]  frac_digits;
  logic [7:0]  sfx [SUFFIX_MAX];
  int          sfx_len;

  conversion_t expected_q [$];
  int          mismatch_count = 0;
  int          result_count = 0;
  int          string_count = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;
  int          status_seen [4];

  function automatic bit is_blank(logic [7:0] c);
    return c == 8'h20 || c == 8'h09;
  endfunction

  function automatic void clear_parser();
    phase = s2i_pkg::PH_LEAD;
    acc = '0;
    wrapped = 1'b0;
    point = 1'b0;
    any_digit = 1'b0;
    frac_digits = '0;
    sfx_len = 0;
    too_long = 1'b0;
  endfunction

  function automatic void parse_char(logic [7:0] c);
    logic [63:0] d;
    if (phase == s2i_pkg::PH_LEAD) begin
      if (is_blank(c)) return;
      phase = s2i_pkg::PH_DIGITS;
    end
    if (phase == s2i_pkg::PH_DIGITS) begin
      if (c >= "0" && c <= "9") begin
        d = 64'(c - 8'h30);
        if (acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 64'd10) wrapped = 1'b1;
        acc = acc * 64'd10 + d;
        any_digit = 1'b1;
        if (point && frac_digits < 5'd31) frac_digits++;
        return;
      end
      if (c == "." && !point) begin
        point = 1'b1;
        return;
      end
      phase = s2i_pkg::PH_GAP;
    end
    if (phase == s2i_pkg::PH_GAP) begin
      if (is_blank(c)) return;
      phase = s2i_pkg::PH_SUFFIX;
    end
    if (sfx_len < SUFFIX_MAX) begin
      sfx[sfx_len] = c;
      sfx_len++;
    end else begin
      too_long = 1'b1;
    end
  endfunction

  // suffix lookup against our own table, text stored plainly
  function automatic bit lookup_unit(logic [2:0] kind, output logic [31:0] factor,
                                     output int shift);
    string names [31] = '{"mm", "m", "km", "ft", "yd", "miles", "mm/s", "m/s",
      "km/h", "mph", "ms", "s", "m", "min", "h", "N", "kN", "MN", "lbf", "kg",
      "t", "st", "lt", "W", "kW", "MW", "GW", "hp", "ft lbf/s", "N/(m/s)",
      "N/(m/s)^2"};
    int kinds [31] = '{0, 0, 0, 0, 0, 0, 1, 1, 1, 1, 2, 2, 2, 2, 2, 3, 3, 3, 3,
      4, 4, 4, 4, 5, 5, 5, 5, 5, 5, 6, 7};
    int factors [31] = '{1, 1000, 1000000, 305, 914, 1609344, 1, 1000, 278, 447,
      1, 1000, 60000, 60000, 3600000, 1, 1000, 1000000, 4555, 1, 1000, 907,
      1016, 1, 1000, 1000000, 1000000000, 746, 684, 1, 1};
    int shifts [31] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 10,
      0, 0, 0, 0, 0, 0, 0, 0, 0, 9, 0, 0};
    bit same;
    factor = 0;
    shift = 0;
    for (int i = 0; i < 31; i++) begin
      if (kinds[i] != kind || names[i].len() != sfx_len) continue;
      same = 1'b1;
      for (int j = 0; j < sfx_len; j++)
        if (names[i][j] != sfx[j]) same = 1'b0;
      if (same) begin
        factor = factors[i];
        shift = shifts[i];
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic conversion_t finish_string(logic [2:0] kind);
    conversion_t r;
    logic [63:0] v, p;
    logic [127:0] prod;
    logic [31:0] factor;
    int shift;
    bit wrap;
    r.val = '0;
    v = acc;
    wrap = wrapped;
    if (!any_digit) begin
      r.stat = s2i_pkg::ST_NO_DIGITS;
      return r;
    end
    if (sfx_len > 0 || too_long) begin
      if (too_long || !lookup_unit(kind, factor, shift)) begin
        r.stat = s2i_pkg::ST_UNKNOWN;
        return r;
      end
      prod = 128'(v) * 128'(factor);
      if (prod[127:64] != 0) wrap = 1'b1;
      v = prod[63:0] >> shift;
    end
    if (wrap) begin
      r.stat = s2i_pkg::ST_WRAP;
      return r;
    end
    if (frac_digits > 5'd19) begin
      v = '0;
    end else if (frac_digits > 0) begin
      p = 64'd1;
      for (int i = 0; i < frac_digits; i++) p = p * 64'd10;
      v = v / p;
    end
    r.val = v;
    r.stat = s2i_pkg::ST_OK;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %0d, expected %0d (result %0d)", what, got, want,
             result_count);
    mismatch_count++;
  endtask

  // one transfer into the parser
  task automatic send_char(logic [7:0] c, bit has, bit lst, logic [2:0] kind);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    character <= c;
    has_character <= has;
    last <= lst;
    unit_kind <= kind;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (has) parse_char(c);
    if (lst) begin
      expected_q.push_back(finish_string(kind));
      clear_parser();
      string_count++;
    end
    @(negedge clk);
  endtask

  task automatic send_string(string s, logic [2:0] kind);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], 1'b1, i == s.len() - 1, kind);
    if (s.len() == 0) send_char(8'h00, 1'b0, 1'b1, kind);
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    conversion_t want;
    if (!rst && out_valid && !out_stall) begin
      result_count++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", value, 64'd0);
      end else begin
        want = expected_q.pop_front();
        if (status !== want.stat)
          report_mismatch("status", 64'(status), 64'(want.stat));
        if (value !== want.val) report_mismatch("value", value, want.val);
        status_seen[want.stat]++;
      end
    end
  end

  initial begin
    int gap;
    gap = 0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_stall <= 1'b0;
      end else if (gap > 0) begin
        gap--;
      end else if ($urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        gap = $urandom_range(1, 6);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no transfer on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog expired");
      $display("status: fail");
      $finish;
    end
  end

  task automatic test_directed_units();
    send_string("12mm", 3'd0);
    send_string("  1.5 km", 3'd0);
    send_string("3 miles", 3'd0);
    send_string("100km/h", 3'd1);
    send_string("2.5min", 3'd2);
    send_string("10 lbf", 3'd3);
    send_string("7.25t", 3'd4);
    send_string("100ft lbf/s", 3'd5);
    send_string("4N/(m/s)", 3'd6);
    send_string("\t9N/(m/s)^2", 3'd7);
    send_string("5", 3'd2);
  endtask

  task automatic test_directed_errors();
    send_string("  kg", 3'd4);                      // no digits
    send_string("", 3'd1);                          // empty final item only
    send_string("5 furlongs", 3'd0);                // unknown suffix
    send_string("5kg ", 3'd4);                      // trailing blank is part of suffix
    send_string("1xxxxxxxxxxxxxxxxxxx", 3'd0);      // suffix too long
    send_string("18446744073709551615", 3'd3);      // largest value
    send_string("18446744073709551616", 3'd3);      // digit wrap
    send_string("18446744073709551615GW", 3'd5);    // product wrap
    send_string("1.2.3m", 3'd0);                    // second point starts suffix
    send_string("1.000000000000000000001", 3'd0);   // more than 19 fraction digits
    send_string({"255", string'(8'hff)}, 3'd0);
    send_char("8", 1'b1, 1'b0, 3'd0);
    send_char(8'h00, 1'b0, 1'b0, 3'd0);             // ignored character
    send_char("s", 1'b1, 1'b0, 3'd6);
    send_char(8'h00, 1'b0, 1'b1, 3'd2);             // kind from last transfer only
  endtask

  function automatic string random_number();
    string s;
    int n;
    s = "";
    repeat ($urandom_range(0, 2)) s = {s, ($urandom_range(0, 1) ? " " : "\t")};
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 24) : $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      s = {s, string'(8'($urandom_range(48, 57)))};
      if (i == n / 2 && $urandom_range(0, 2) == 0) s = {s, "."};
    end
    repeat ($urandom_range(0, 1)) s = {s, " "};
    return s;
  endfunction

  task automatic test_random_strings(int count);
    string units [31] = '{"mm", "m", "km", "ft", "yd", "miles", "mm/s", "m/s",
      "km/h", "mph", "ms", "s", "m", "min", "h", "N", "kN", "MN", "lbf", "kg",
      "t", "st", "lt", "W", "kW", "MW", "GW", "hp", "ft lbf/s", "N/(m/s)",
      "N/(m/s)^2"};
    string s;
    int pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        // well formed, with no suffix or a real suffix of any kind
        s = {random_number(), pick < 2 ? "" : units[$urandom_range(0, 30)]};
        send_string(s, 3'($urandom_range(0, 7)));
      end else if (pick < 9) begin
        s = random_number();
        repeat ($urandom_range(1, 4)) s = {s, string'(8'($urandom_range(1, 255)))};
        send_string(s, 3'($urandom_range(0, 7)));
      end else begin
        // raw noise including empty items
        repeat ($urandom_range(0, 8))
          send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0,
                    3'($urandom_range(0, 7)));
        send_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1,
                  3'($urandom_range(0, 7)));
      end
    end
  endtask

  initial begin
    int wait_cycles;
    clear_parser();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed_units();
    test_directed_errors();
    test_random_strings(50);
    quiet = 1'b1;
    test_random_strings(15);
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (expected_q.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (100) @(posedge clk);
    $display("strings sent %0d, results checked %0d", string_count, result_count);
    $display("ok %0d, no digits %0d, unknown suffix %0d, wrap %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
